// ===== rtl/srp_pkg.sv =====
// Serpent-256 encryption core: shared types, constants and S-box/linear-transform functions.
package srp_pkg;

  localparam int unsigned KeyRegs   = 4;
  localparam int unsigned KeyIdxW   = $clog2(KeyRegs);
  localparam int unsigned RoundW    = 6;
  localparam logic [RoundW-1:0] LastRound = RoundW'(32);
  localparam logic [RoundW-1:0] MixSkipRound = RoundW'(31);
  localparam logic [31:0] GoldenPhi = 32'h9e37_79b9;

  typedef logic [3:0][31:0] word4_t;
  typedef logic [7:0][31:0] window_t;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StHold
  } state_e;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [RoundW-1:0] round;
  } ks_ctrl_t;

  // Entry 2k is the low nibble and entry 2k+1 the high nibble of byte k.
  localparam logic [7:0] SboxBytes [8][8] = '{
    '{8'h83, 8'h1F, 8'h6A, 8'hB5, 8'hDE, 8'h24, 8'h07, 8'hC9},
    '{8'hCF, 8'h72, 8'h09, 8'hA5, 8'hB1, 8'h8E, 8'hD6, 8'h43},
    '{8'h68, 8'h97, 8'hC3, 8'hFA, 8'h1D, 8'h4E, 8'hB0, 8'h25},
    '{8'hF0, 8'h8B, 8'h9C, 8'h36, 8'h1D, 8'h42, 8'h7A, 8'hE5},
    '{8'hF1, 8'h38, 8'h0C, 8'h6B, 8'h52, 8'hA4, 8'hE9, 8'hD7},
    '{8'h5F, 8'hB2, 8'hA4, 8'hC9, 8'h30, 8'h8E, 8'h6D, 8'h17},
    '{8'h27, 8'h5C, 8'h48, 8'hB6, 8'h9E, 8'hF1, 8'h3D, 8'h0A},
    '{8'hD1, 8'h0F, 8'h8E, 8'hB2, 8'h47, 8'hAC, 8'h39, 8'h65}
  };

  function automatic logic [3:0] sbox_nib(input logic [2:0] box, input logic [3:0] v);
    logic [7:0] b;
    b = SboxBytes[box][v[3:1]];
    return v[0] ? b[7:4] : b[3:0];
  endfunction

  function automatic word4_t slice_sbox(input word4_t w, input logic [2:0] box);
    word4_t     o;
    logic [3:0] nib;
    o = '0;
    for (int b = 0; b < 32; b++) begin
      nib = sbox_nib(box, {w[3][b], w[2][b], w[1][b], w[0][b]});
      for (int q = 0; q < 4; q++) begin
        o[q][b] = nib[q];
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic word4_t linear_mix(input word4_t xi);
    word4_t x;
    x = xi;
    x[0] = rotl32(x[0], 13);
    x[2] = rotl32(x[2], 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = rotl32(x[1], 1);
    x[3] = rotl32(x[3], 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = rotl32(x[0], 5);
    x[2] = rotl32(x[2], 22);
    return x;
  endfunction

endpackage

// ===== rtl/srp_keysched.sv =====
// Serpent key schedule: prekey window register and on-the-fly subkey generation.
module srp_keysched import srp_pkg::*; (
  input  logic     clk_i,
  input  ks_ctrl_t ctrl_i,
  input  window_t  key_i,
  output word4_t   subkey_o
);

  window_t win_q, win_d;
  window_t win_c;
  word4_t  pre;
  logic [31:0] w;
  logic [7:0]  cnt;

  always_comb begin
    win_c = win_q;
    pre   = '0;
    for (int j = 0; j < 4; j++) begin
      cnt = {ctrl_i.round, 2'b00} + 8'(j);
      w   = win_c[0] ^ win_c[3] ^ win_c[5] ^ win_c[7] ^ GoldenPhi ^ {24'd0, cnt};
      w   = rotl32(w, 11);
      for (int s = 0; s < 7; s++) begin
        win_c[s] = win_c[s+1];
      end
      win_c[7] = w;
      pre[j]   = w;
    end
    subkey_o = slice_sbox(pre, 3'(3'd3 - ctrl_i.round[2:0]));
  end

  always_comb begin
    win_d = win_q;
    if (ctrl_i.load) begin
      win_d = key_i;
    end else if (ctrl_i.step) begin
      win_d = win_c;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ===== rtl/srp_round.sv =====
// Serpent round unit: subkey XOR, bitsliced S-box and linear transform (skipped in round 31).
module srp_round import srp_pkg::*; (
  input  word4_t            x_i,
  input  word4_t            subkey_i,
  input  logic [RoundW-1:0] round_i,
  output word4_t            x_next_o,
  output word4_t            result_o
);

  word4_t mixed;
  word4_t subbed;

  always_comb begin
    mixed    = x_i ^ subkey_i;
    subbed   = slice_sbox(mixed, round_i[2:0]);
    result_o = mixed;
    x_next_o = (round_i == MixSkipRound) ? subbed : linear_mix(subbed);
  end

endmodule

// ===== rtl/serpent256_block_encrypt_core.sv =====
// Serpent-256 block encryption core: top level with key registers and round sequencer.
//
// Encrypts one 128-bit word per accepted input under the 256-bit key held in four
// 64-bit registers. One round unit is reused for all 32 rounds and the final subkey
// addition, one per cycle, with the key schedule stepped alongside it; a new word
// is taken only once the round loop of the last one is over and the core is idle.
// The output register decouples the result; a new word is accepted while the
// previous ciphertext waits, and the core holds its result only if that register
// is still full at the end of the round loop. Key registers must be written while idle.
module serpent256_block_encrypt_core import srp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [KeyIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [127:0]        s_axis_tdata_i,   // plain_low [63:0], plain_high [127:64]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [127:0]        m_axis_tdata_o    // cipher_low [63:0], cipher_high [127:64]
);

  logic [KeyRegs-1:0][63:0] key_q;
  state_e            state_q, state_d;
  logic [RoundW-1:0] round_q, round_d;
  word4_t            x_q, x_d;
  word4_t            out_q;
  logic              m_valid_q, m_valid_d;
  logic              in_acc, out_free, out_load;
  ks_ctrl_t          ks_ctrl;
  word4_t            subkey, x_next, result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  srp_keysched u_keysched (
    .clk_i    (clk_i),
    .ctrl_i   (ks_ctrl),
    .key_i    (window_t'(key_q)),
    .subkey_o (subkey)
  );

  srp_round u_round (
    .x_i      (x_q),
    .subkey_i (subkey),
    .round_i  (round_q),
    .x_next_o (x_next),
    .result_o (result)
  );

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StRun;
      StRun: begin
        if (round_q == LastRound) state_d = out_free ? StIdle : StHold;
      end
      StHold: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    ks_ctrl         = '0;
    ks_ctrl.round   = round_q;
    round_d         = round_q;
    x_d             = x_q;
    out_load        = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          ks_ctrl.load = 1'b1;
          round_d      = '0;
          x_d          = word4_t'(s_axis_tdata_i);
        end
      end
      StRun: begin
        ks_ctrl.step = 1'b1;
        round_d      = round_q + RoundW'(1);
        if (round_q == LastRound) begin
          x_d      = result;
          out_load = out_free;
        end else begin
          x_d = x_next;
        end
      end
      StHold: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      round_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      round_q   <= round_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (out_load) begin
      out_q <= (state_q == StRun) ? result : x_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = 128'(out_q);

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (round_q <= LastRound))
    else $error("round counter past last round");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StRun && round_q == '0))
    else $error("accepted word did not start round loop");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("output register overwritten while full");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StHold) |-> m_valid_q)
    else $error("holding result with empty output register");

endmodule

// ===== dv/serpent256_block_encrypt_core_tb.sv =====
// Testbench for the Serpent-256 encryption core: directed and random blocks checked against a predictor.
`timescale 1ns / 100ps

module serpent256_block_encrypt_core_tb;
  import srp_pkg::*;

  localparam int CycleLimit   = 500_000;
  localparam int SettleCycles = 40;
  localparam logic [31:0] Phi = 32'h9e37_79b9;

  typedef enum logic [KeyIdxW-1:0] {
    KeyRegW01 = 0,
    KeyRegW23 = 1,
    KeyRegW45 = 2,
    KeyRegW67 = 3
  } key_reg_e;

  typedef logic [3:0][31:0] quad_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  // nibble v of box n sits at bits 4v+3:4v
  localparam logic [63:0] SerpSbox [8] = '{
    64'hC907_24DE_B56A_1F83,
    64'h43D6_8EB1_A509_72CF,
    64'h25B0_4E1D_FAC3_9768,
    64'hE57A_421D_369C_8BF0,
    64'hD7E9_A452_6B0C_38F1,
    64'h176D_8E30_C9A4_B25F,
    64'h0A3D_F19E_B648_5C27,
    64'h6539_AC47_B28E_0FD1
  };

  localparam int DirRows = 14;
  localparam plain_t DirPlain [DirRows] = '{
    '{64'h0, 64'h0},
    '{'1, '1},
    '{'1, 64'h0},
    '{64'h0, '1},
    '{64'h0, 64'h1},
    '{64'h8000_0000_0000_0000, 64'h0},
    '{64'h0, 64'h8000_0000_0000_0000},
    '{64'h1, 64'h0},
    '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA},
    '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF},
    '{64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF},
    '{64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001},
    '{64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [KeyIdxW-1:0] cfg_idx = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_valid = 1'b0;
  logic [127:0] s_data = '0;
  logic         m_ready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [127:0] m_axis_tdata_o;

  logic [63:0]  key_mirror [KeyRegs] = '{default: '0};
  cipher_t      cipher_q [$];
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  int           tx_gap_max = 0;
  int           rx_stall_max = 0;

  serpent256_block_encrypt_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic quad_t sbox_slices(input quad_t w, input logic [2:0] box);
    quad_t      o;
    logic [3:0] nib_in;
    logic [3:0] nib_out;
    o = '0;
    for (int b = 0; b < 32; b++) begin
      nib_in = {w[3][b], w[2][b], w[1][b], w[0][b]};
      nib_out = SerpSbox[box][4*nib_in +: 4];
      for (int q = 0; q < 4; q++) begin
        o[q][b] = nib_out[q];
      end
    end
    return o;
  endfunction

  function automatic quad_t lin_mix(input quad_t xi);
    quad_t x;
    x = xi;
    x[0] = rol32(x[0], 13);
    x[2] = rol32(x[2], 3);
    x[1] = x[1] ^ x[0] ^ x[2];
    x[3] = x[3] ^ x[2] ^ (x[0] << 3);
    x[1] = rol32(x[1], 1);
    x[3] = rol32(x[3], 7);
    x[0] = x[0] ^ x[1] ^ x[3];
    x[2] = x[2] ^ x[3] ^ (x[1] << 7);
    x[0] = rol32(x[0], 5);
    x[2] = rol32(x[2], 22);
    return x;
  endfunction

  function automatic cipher_t serpent_encrypt(input plain_t pt);
    logic [7:0][31:0] win;
    quad_t            sk;
    quad_t            x;
    logic [31:0]      w;
    logic [31:0]      widx;
    for (int j = 0; j < KeyRegs; j++) begin
      win[2*j]   = key_mirror[j][31:0];
      win[2*j+1] = key_mirror[j][63:32];
    end
    x = pt;
    widx = '0;
    for (int r = 0; r <= 32; r++) begin
      for (int j = 0; j < 4; j++) begin
        w = rol32(win[0] ^ win[3] ^ win[5] ^ win[7] ^ Phi ^ widx, 11);
        widx++;
        win = {w, win[7:1]};
        sk[j] = w;
      end
      x = x ^ sbox_slices(sk, 3'(35 - r));
      if (r < 32) begin
        x = sbox_slices(x, 3'(r));
        if (r != 31) x = lin_mix(x);
      end
    end
    return x;
  endfunction

  function automatic void note_error(input string what, input logic [63:0] exp_v,
                                     input logic [63:0] got_v);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: %s mismatch: expected %h got %h", $realtime, what, exp_v, got_v);
    end
  endfunction

  function automatic void check_cipher(input cipher_t got);
    cipher_t exp_c;
    if (cipher_q.size() == 0) begin
      note_error("unexpected word", 64'h0, got.cipher_low);
      return;
    end
    exp_c = cipher_q.pop_front();
    if (got.cipher_low !== exp_c.cipher_low) begin
      note_error("cipher_low", exp_c.cipher_low, got.cipher_low);
    end
    if (got.cipher_high !== exp_c.cipher_high) begin
      note_error("cipher_high", exp_c.cipher_high, got.cipher_high);
    end
  endfunction

  function automatic logic [63:0] rand_dword();
    case ($urandom_range(15, 0))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // caller is at a rising edge; leaves we high, caller drops it
  task automatic write_key_reg(input key_reg_e idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    key_mirror[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic load_full_key(input logic [63:0] k01, k23, k45, k67);
    write_key_reg(KeyRegW01, k01);
    write_key_reg(KeyRegW23, k23);
    write_key_reg(KeyRegW45, k45);
    write_key_reg(KeyRegW67, k67);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(input plain_t pt, input bit drain);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (drain || gap > 0) s_valid <= 1'b0;
    if (drain) begin
      wait (cipher_q.size() == 0);
      @(posedge clk_i);
    end
    repeat (gap) @(posedge clk_i);
    s_valid <= 1'b1;
    s_data <= pt;
    do @(posedge clk_i); while (!s_axis_tready_o);
    cipher_q.push_back(serpent_encrypt(pt));
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    wait (cipher_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_table();
    for (int i = 0; i < DirRows; i++) begin
      send_block(DirPlain[i], 1'b0);
    end
  endtask

  task automatic run_random(input int n);
    plain_t pt;
    for (int i = 0; i < n; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2, 0))
          0: tx_gap_max = 0;
          1: tx_gap_max = 16;
          default: tx_gap_max = $urandom_range(16, 0);
        endcase
        case ($urandom_range(2, 0))
          0: rx_stall_max = 0;
          1: rx_stall_max = 16;
          default: rx_stall_max = $urandom_range(16, 0);
        endcase
      end
      pt.plain_low = rand_dword();
      pt.plain_high = rand_dword();
      send_block(pt, $urandom_range(39, 0) == 0);
    end
  endtask

  initial begin : cipher_sink
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(rx_stall_max, 0);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      check_cipher(m_axis_tdata_o);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, back to back
    tx_gap_max = 0;
    rx_stall_max = 0;
    run_table();
    settle();

    // all-ones key, heavy idling
    tx_gap_max = 16;
    rx_stall_max = 16;
    load_full_key('1, '1, '1, '1);
    run_table();
    settle();

    load_full_key({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    run_random(100);
    settle();

    // single register update keeps the others
    write_key_reg(KeyRegW45, {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(posedge clk_i);
    run_random(60);
    settle();

    load_full_key(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    run_random(60);
    settle();

    write_key_reg(KeyRegW01, '0);
    write_key_reg(KeyRegW67, '1);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    run_random(60);
    settle();

    load_full_key({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
    run_random(170);

    s_valid <= 1'b0;
    wait (cipher_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && cipher_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
